FILE: hw/rtl/plist_pkg.sv
// Shared operation codes, status codes and field widths of the positional list engine.
`default_nettype none

package plist_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plist_mem.sv
// Entry memory with one write port and one registered read port.
`default_nettype none

module plist_mem #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [WORD_BITS-1:0]         rd_data,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [WORD_BITS-1:0]         wr_data
);

  logic [WORD_BITS-1:0] mem_r [DEPTH];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/plist_ctrl.sv
// Sequencer that checks requests, moves entries through the memory and drives the result register.
`default_nettype none

module plist_ctrl #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [plist_pkg::OP_W-1:0]         in_operation,
  input  wire logic [plist_pkg::POS_W-1:0]        in_position,
  input  wire logic [WORD_BITS-1:0]               in_payload,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [plist_pkg::STATUS_W-1:0]     out_status,
  output logic      [WORD_BITS-1:0]               out_word_out,
  output logic      [plist_pkg::COUNT_W-1:0]      out_count_out,
  output logic                                    out_last,
  output logic                                    mem_rd_en,
  output logic      [$clog2(DEPTH)-1:0]           mem_rd_addr,
  input  wire logic [WORD_BITS-1:0]               mem_rd_data,
  output logic                                    mem_wr_en,
  output logic      [$clog2(DEPTH)-1:0]           mem_wr_addr,
  output logic      [WORD_BITS-1:0]               mem_wr_data
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SHIFT = 7'b0000010,
    S_TAKE  = 7'b0000100,
    S_CLOSE = 7'b0001000,
    S_DRD   = 7'b0010000,
    S_DEM   = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [WORD_BITS-1:0]      word_r, word_nxt;
  logic                      wpend_r, wpend_nxt;
  logic [AW-1:0]             wa_r, wa_nxt;
  plist_pkg::status_t        resp_status_r, resp_status_nxt;
  logic [WORD_BITS-1:0]      resp_word_r, resp_word_nxt;

  logic                      out_valid_r, out_valid_nxt;
  plist_pkg::status_t        out_status_r, out_status_nxt;
  logic [WORD_BITS-1:0]      out_word_r, out_word_nxt;
  logic [plist_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      slot_free;
  logic [CMPW-1:0]           pos_ext;
  logic [CMPW-1:0]           cnt_ext;
  logic [CW-1:0]             idx_dec;
  logic [CW-1:0]             idx_inc;
  logic                      dump_last;

  assign slot_free = !out_valid_r || out_ready;
  assign pos_ext   = CMPW'(in_position);
  assign cnt_ext   = CMPW'(count_r);
  assign idx_dec   = idx_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign dump_last = (idx_inc == count_r);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    word_nxt        = word_r;
    wpend_nxt       = wpend_r;
    wa_nxt          = wa_r;
    resp_status_nxt = resp_status_r;
    resp_word_nxt   = resp_word_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_word_nxt    = out_word_r;
    out_count_nxt   = out_count_r;
    out_last_nxt    = out_last_r;
    in_ready        = (state_r == S_IDLE);
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = wa_r;
    mem_wr_data     = mem_rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            plist_pkg::OP_INSERT: begin
              if (pos_ext > cnt_ext) begin
                resp_status_nxt = plist_pkg::ST_BAD_POS;
                resp_word_nxt   = '0;
                state_nxt       = S_RESP;
              end else if (count_r == CW'(DEPTH)) begin
                resp_status_nxt = plist_pkg::ST_FULL;
                resp_word_nxt   = '0;
                state_nxt       = S_RESP;
              end else begin
                idx_nxt   = count_r;
                pos_nxt   = CW'(in_position);
                word_nxt  = in_payload;
                wpend_nxt = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            plist_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                resp_status_nxt = plist_pkg::ST_EMPTY;
                resp_word_nxt   = '0;
                state_nxt       = S_RESP;
              end else if (pos_ext >= cnt_ext) begin
                resp_status_nxt = plist_pkg::ST_BAD_POS;
                resp_word_nxt   = '0;
                state_nxt       = S_RESP;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(in_position);
                idx_nxt     = CW'(in_position);
                state_nxt   = S_TAKE;
              end
            end
            plist_pkg::OP_DUMP: begin
              if (count_r == '0) begin
                resp_status_nxt = plist_pkg::ST_OK;
                resp_word_nxt   = '0;
                state_nxt       = S_RESP;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DRD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (wpend_r) begin
          mem_wr_en = 1'b1;
        end
        if (idx_r > pos_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_dec[AW-1:0];
          wa_nxt      = idx_r[AW-1:0];
          wpend_nxt   = 1'b1;
          idx_nxt     = idx_dec;
        end else if (!wpend_r) begin
          mem_wr_en       = 1'b1;
          mem_wr_addr     = pos_r[AW-1:0];
          mem_wr_data     = word_r;
          count_nxt       = count_r + CW'(1);
          resp_status_nxt = plist_pkg::ST_OK;
          resp_word_nxt   = '0;
          state_nxt       = S_RESP;
        end else begin
          wpend_nxt = 1'b0;
        end
      end
      S_TAKE: begin
        resp_word_nxt = mem_rd_data;
        wpend_nxt     = 1'b0;
        state_nxt     = S_CLOSE;
      end
      S_CLOSE: begin
        if (wpend_r) begin
          mem_wr_en = 1'b1;
        end
        if (idx_inc < count_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_inc[AW-1:0];
          wa_nxt      = idx_r[AW-1:0];
          wpend_nxt   = 1'b1;
          idx_nxt     = idx_inc;
        end else if (!wpend_r) begin
          count_nxt       = count_r - CW'(1);
          resp_status_nxt = plist_pkg::ST_OK;
          state_nxt       = S_RESP;
        end else begin
          wpend_nxt = 1'b0;
        end
      end
      S_DRD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = idx_r[AW-1:0];
        state_nxt   = S_DEM;
      end
      S_DEM: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = plist_pkg::ST_OK;
          out_word_nxt   = mem_rd_data;
          out_count_nxt  = plist_pkg::COUNT_W'(count_r);
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_DRD;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_status_r;
          out_word_nxt   = resp_word_r;
          out_count_nxt  = plist_pkg::COUNT_W'(count_r);
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    word_r        <= word_nxt;
    wa_r          <= wa_nxt;
    resp_status_r <= resp_status_nxt;
    resp_word_r   <= resp_word_nxt;
    out_status_r  <= out_status_nxt;
    out_word_r    <= out_word_nxt;
    out_count_r   <= out_count_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_word_out  = out_word_r;
  assign out_count_out = out_count_r;
  assign out_last      = out_last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("Entry count exceeds the list capacity.");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en && (mem_wr_addr == mem_rd_addr)))
    else $error("Memory read and write hit the same entry in one cycle.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + CW'(1)) || (count_r == $past(count_r) - CW'(1))))
    else $error("Entry count moved by more than one.");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> (state_r == S_RESP))
    else $error("Entry count changed without a pending result.");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_engine_top.sv
// Top level of the positional list engine: entry memory and sequencer.
`default_nettype none

// The engine keeps an ordered list of up to DEPTH words in a synchronous memory and takes
// insert, remove and dump requests one at a time. An insert at position p moves the entries
// from p to the tail back one slot at a time through the memory; a remove closes the gap in
// the same way, moving the entries after p forward one slot at a time.
// Both are paced by the single read port of the entry memory, which moves one entry per cycle.
// A dump gives one result per entry, one memory read each, and the last result carries the
// last flag. Errors and an empty dump give a single result, which passes through the S_RESP
// state into the output register. A finished result is held in the output register, so the
// next request can be taken while it waits. The entry memory needs no clearing after reset.
module positional_list_engine_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [plist_pkg::OP_W-1:0]        in_operation,
  input  wire logic [plist_pkg::POS_W-1:0]       in_position,
  input  wire logic [WORD_BITS-1:0]              in_payload,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [plist_pkg::STATUS_W-1:0]    out_status,
  output logic      [WORD_BITS-1:0]              out_word_out,
  output logic      [plist_pkg::COUNT_W-1:0]     out_count_out,
  output logic                                   out_last
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;
  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;

  plist_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  plist_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_payload    (in_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_word_out  (out_word_out),
    .out_count_out (out_count_out),
    .out_last      (out_last),
    .mem_rd_en     (mem_rd_en),
    .mem_rd_addr   (mem_rd_addr),
    .mem_rd_data   (mem_rd_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data)
  );

endmodule

`default_nettype wire

FILE: test/tb_positional_list_engine_top.sv
// Testbench for the positional list engine: directed and random list traffic with a shadow list.
module tb_positional_list_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned AW          = $clog2(DEPTH);
  localparam int unsigned STALL_LIMIT = 5000;
  localparam logic [plist_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    plist_pkg::status_t              status;
    logic [WORD_BITS-1:0]            word;
    logic [plist_pkg::COUNT_W-1:0]   count;
    logic                            last;
  } list_result_t;

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_ready;
  logic [plist_pkg::OP_W-1:0]      in_operation = '0;
  logic [plist_pkg::POS_W-1:0]     in_position  = '0;
  logic [WORD_BITS-1:0]            in_payload   = '0;
  logic                            out_valid;
  logic                            out_ready    = 1'b0;
  logic [plist_pkg::STATUS_W-1:0]  out_status;
  logic [WORD_BITS-1:0]            out_word_out;
  logic [plist_pkg::COUNT_W-1:0]   out_count_out;
  logic                            out_last;

  logic [WORD_BITS-1:0] shadow_words [DEPTH];
  int unsigned          shadow_count = 0;
  list_result_t         pending_results [$];
  list_result_t         want;
  int unsigned          fail_count    = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  int unsigned          stall_cycles  = 0;

  positional_list_engine_top #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_payload    (in_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_word_out  (out_word_out),
    .out_count_out (out_count_out),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Applies one accepted request to the shadow list and queues the results it causes.
  task automatic predict_outcome(input logic [plist_pkg::OP_W-1:0] op,
                                 input logic [plist_pkg::POS_W-1:0] pos,
                                 input logic [WORD_BITS-1:0] word);
    list_result_t r;
    int unsigned  p;
    int unsigned  i;
    p = 32'(pos);
    r = '{status: plist_pkg::ST_OK, word: '0, count: '0, last: 1'b1};
    case (op)
      plist_pkg::OP_INSERT: begin
        if (p > shadow_count) begin
          r.status = plist_pkg::ST_BAD_POS;
        end else if (shadow_count >= DEPTH) begin
          r.status = plist_pkg::ST_FULL;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_words[AW'(i)] = shadow_words[AW'(i-1)];
          shadow_words[AW'(p)] = word;
          shadow_count++;
        end
        r.count = plist_pkg::COUNT_W'(shadow_count);
        pending_results.push_back(r);
      end
      plist_pkg::OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = plist_pkg::ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = plist_pkg::ST_BAD_POS;
        end else begin
          r.word = shadow_words[AW'(p)];
          for (i = p; i + 1 < shadow_count; i++) shadow_words[AW'(i)] = shadow_words[AW'(i+1)];
          shadow_count--;
        end
        r.count = plist_pkg::COUNT_W'(shadow_count);
        pending_results.push_back(r);
      end
      plist_pkg::OP_DUMP: begin
        if (shadow_count == 0) begin
          pending_results.push_back(r);
        end else begin
          for (i = 0; i < shadow_count; i++) begin
            r.word  = shadow_words[AW'(i)];
            r.count = plist_pkg::COUNT_W'(shadow_count);
            r.last  = (i + 1 == shadow_count);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_field(input string name, input logic [WORD_BITS-1:0] expected,
                              input logic [WORD_BITS-1:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, %s %0d word %h count %0d last %b",
                 $time, "actual status", out_status, out_word_out, out_count_out, out_last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("status", WORD_BITS'(want.status), WORD_BITS'(out_status));
        report_field("word_out", want.word, out_word_out);
        report_field("count_out", WORD_BITS'(want.count), WORD_BITS'(out_count_out));
        report_field("last", WORD_BITS'(want.last), WORD_BITS'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [plist_pkg::OP_W-1:0] op,
                           input logic [plist_pkg::POS_W-1:0] pos,
                           input logic [WORD_BITS-1:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_payload   <= word;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    predict_outcome(op, pos, word);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] random_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_list();
    send_item(plist_pkg::OP_DUMP, 5'd0, random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd0, random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd31, random_word());
    send_item(plist_pkg::OP_INSERT, 5'd1, random_word());
    send_item(plist_pkg::OP_INSERT, 5'd0, '1);
    send_item(plist_pkg::OP_DUMP, 5'd0, '0);
  endtask

  task automatic test_insert_remove_edges();
    send_item(plist_pkg::OP_INSERT, plist_pkg::POS_W'(shadow_count), '0);
    send_item(plist_pkg::OP_INSERT, 5'd0, 32'h1234_5678);
    send_item(plist_pkg::OP_INSERT, 5'd1, 32'hA5A5_5A5A);
    send_item(plist_pkg::OP_REMOVE, plist_pkg::POS_W'(shadow_count), random_word());
    send_item(plist_pkg::OP_INSERT, plist_pkg::POS_W'(shadow_count + 1), random_word());
    send_item(OP_UNUSED, 5'd31, '1);
    send_item(plist_pkg::OP_DUMP, 5'd0, random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd1, random_word());
    send_item(plist_pkg::OP_REMOVE, plist_pkg::POS_W'(shadow_count - 1), random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd0, random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd0, random_word());
    send_item(plist_pkg::OP_DUMP, 5'd0, random_word());
  endtask

  task automatic test_full_list();
    while (shadow_count < DEPTH) begin
      send_item(plist_pkg::OP_INSERT, plist_pkg::POS_W'($urandom_range(shadow_count)),
                random_word());
    end
    send_item(plist_pkg::OP_INSERT, plist_pkg::POS_W'(DEPTH), random_word());
    send_item(plist_pkg::OP_INSERT, 5'd0, random_word());
    send_item(plist_pkg::OP_INSERT, plist_pkg::POS_W'(DEPTH + 1), random_word());
    send_item(plist_pkg::OP_INSERT, 5'd31, random_word());
    send_item(plist_pkg::OP_DUMP, 5'd0, random_word());
    send_item(plist_pkg::OP_REMOVE, plist_pkg::POS_W'(DEPTH), random_word());
    send_item(plist_pkg::OP_REMOVE, plist_pkg::POS_W'(DEPTH - 1), random_word());
    send_item(plist_pkg::OP_REMOVE, 5'd0, random_word());
    // Hold off new requests until the list has answered everything so far.
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned                 k;
    int unsigned                 pick;
    int unsigned                 fill_goal;
    logic [plist_pkg::OP_W-1:0]  op;
    logic [plist_pkg::POS_W-1:0] pos;
    fill_goal = $urandom_range(DEPTH);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(19) == 0) fill_goal = $urandom_range(DEPTH);
      pick = $urandom_range(99);
      if (pick < 8) begin
        op  = plist_pkg::OP_W'($urandom_range(3));
        pos = plist_pkg::POS_W'($urandom_range(31));
      end else if (pick < 18) begin
        op  = plist_pkg::OP_DUMP;
        pos = plist_pkg::POS_W'($urandom_range(31));
      end else if (shadow_count < fill_goal || (shadow_count == fill_goal && pick < 59)) begin
        op  = plist_pkg::OP_INSERT;
        pos = plist_pkg::POS_W'($urandom_range(shadow_count));
      end else begin
        op  = plist_pkg::OP_REMOVE;
        pos = (shadow_count == 0) ? plist_pkg::POS_W'($urandom_range(31)) :
                                    plist_pkg::POS_W'($urandom_range(shadow_count - 1));
      end
      send_item(op, pos, random_word());
      if ($urandom_range(59) == 0) wait_for_results();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 12;
    recv_idle_pct = 63;
    test_empty_list();
    test_insert_remove_edges();
    test_full_list();
    test_random_traffic(106);
    send_idle_pct = 63;
    recv_idle_pct = 12;
    test_random_traffic(106);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(106);
    wait_for_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: positional_list_engine_top.f
hw/rtl/plist_pkg.sv
hw/rtl/plist_mem.sv
hw/rtl/plist_ctrl.sv
hw/rtl/positional_list_engine_top.sv
test/tb_positional_list_engine_top.sv
